@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/hslp_pkg.sv @@
`default_nettype none

package hslp_pkg;

   // Width of the number accumulators and of the result fields
   localparam int unsigned VALUE_BITS = 16;
   localparam int unsigned OUT_BITS   = 16;
   // Room for acc * 10 + 9 without wrap
   localparam int unsigned WIDE_BITS  = VALUE_BITS + 4;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   // Characters, after folding to lower case
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFS = 8'h20;

   // Bits of the found vector
   localparam logic [1:0] FND_MAJOR  = 2'd0;
   localparam logic [1:0] FND_MINOR  = 2'd1;
   localparam logic [1:0] FND_STATUS = 2'd2;

   typedef enum logic [3:0] {
      PH_H     = 4'd1,
      PH_T1    = 4'd2,
      PH_T2    = 4'd3,
      PH_P     = 4'd4,
      PH_SLASH = 4'd5,
      PH_MAJ0  = 4'd6,
      PH_MAJ   = 4'd7,
      PH_MIN   = 4'd8,
      PH_GAP   = 4'd9,
      PH_STAT  = 4'd10
   } phase_type;

   typedef struct packed {
      phase_type             phase;
      logic                  stopped;
      logic [VALUE_BITS-1:0] acc;
      logic [VALUE_BITS-1:0] major;
      logic [VALUE_BITS-1:0] minor;
      logic [VALUE_BITS-1:0] status;
      logic [2:0]            found;
   } parse_state_type;

   localparam parse_state_type STATE_CLEAR = '{
      phase:   PH_H,
      stopped: 1'b0,
      acc:     '0,
      major:   '0,
      minor:   '0,
      status:  '0,
      found:   3'b000
   };

endpackage

`default_nettype wire

@@ rtl/hslp_step.sv @@
`default_nettype none

// Parser next-state logic for one byte
module hslp_step
   import hslp_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      line_byte,
   output parse_state_type nxt_state
);

   logic [7:0]            ch;
   logic                  is_digit;
   logic                  is_ws;
   logic [VALUE_BITS-1:0] acc_base;
   logic [WIDE_BITS-1:0]  acc_wide;
   logic [WIDE_BITS-1:0]  acc_sum;
   logic [VALUE_BITS-1:0] acc_next;

   // Fold upper-case letters and classify
   always_comb begin
      ch = line_byte;
      if (line_byte >= CH_UC_A && line_byte <= CH_UC_Z) begin
         ch = line_byte + CASE_OFS;
      end
      is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      is_ws    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
   end

   // acc * 10 + digit, saturated at the field maximum
   always_comb begin
      acc_base = cur_state.acc;
      if (cur_state.phase == PH_MAJ0 || cur_state.phase == PH_GAP) begin
         acc_base = '0;
      end
      acc_wide = WIDE_BITS'(acc_base);
      acc_sum  = (acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(ch - CH_ZERO);
      if (acc_sum > WIDE_BITS'(VALUE_MAX)) begin
         acc_next = VALUE_MAX;
      end else begin
         acc_next = acc_sum[VALUE_BITS-1:0];
      end
   end

   // Phase machine
   always_comb begin
      nxt_state = cur_state;
      if (!cur_state.stopped) begin
         unique case (cur_state.phase)
            PH_H: begin
               if (ch == CH_H) nxt_state.phase = PH_T1;
               else            nxt_state.stopped = 1'b1;
            end
            PH_T1: begin
               if (ch == CH_T) nxt_state.phase = PH_T2;
               else            nxt_state.stopped = 1'b1;
            end
            PH_T2: begin
               if (ch == CH_T) nxt_state.phase = PH_P;
               else            nxt_state.stopped = 1'b1;
            end
            PH_P: begin
               if (ch == CH_P) nxt_state.phase = PH_SLASH;
               else            nxt_state.stopped = 1'b1;
            end
            PH_SLASH: begin
               if (ch == CH_SLASH) nxt_state.phase = PH_MAJ0;
               else                nxt_state.stopped = 1'b1;
            end
            PH_MAJ0: begin
               if (is_digit) begin
                  nxt_state.acc   = acc_next;
                  nxt_state.phase = PH_MAJ;
               end else begin
                  nxt_state.stopped = 1'b1;
               end
            end
            PH_MAJ: begin
               if (is_digit) begin
                  nxt_state.acc = acc_next;
               end else if (ch == CH_DOT) begin
                  nxt_state.major            = cur_state.acc;
                  nxt_state.found[FND_MAJOR] = 1'b1;
                  nxt_state.acc              = '0;
                  nxt_state.phase            = PH_MIN;
               end else begin
                  nxt_state.stopped = 1'b1;
               end
            end
            PH_MIN: begin
               if (is_digit) begin
                  nxt_state.acc = acc_next;
               end else if (is_ws) begin
                  nxt_state.minor            = cur_state.acc;
                  nxt_state.found[FND_MINOR] = 1'b1;
                  nxt_state.phase            = PH_GAP;
               end else begin
                  nxt_state.stopped = 1'b1;
               end
            end
            PH_GAP: begin
               if (is_digit) begin
                  nxt_state.acc   = acc_next;
                  nxt_state.phase = PH_STAT;
               end else if (!is_ws) begin
                  nxt_state.stopped = 1'b1;
               end
            end
            PH_STAT: begin
               if (is_digit) begin
                  nxt_state.acc = acc_next;
               end else begin
                  // Whitespace ends the code; anything else stops the line
                  if (is_ws) begin
                     nxt_state.status            = cur_state.acc;
                     nxt_state.found[FND_STATUS] = 1'b1;
                  end
                  nxt_state.stopped = 1'b1;
               end
            end
            default: begin
               nxt_state.stopped = 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/http_status_line_parser.sv @@
// HTTP response status line parser.
// Input channel (req_): one byte of the status line per item, with
// req_end_of_line high on the final byte. Letters are compared without case;
// the line must open with "http/", then major '.' minor, whitespace, status
// code, whitespace. The first unexpected byte stops parsing for that line.
// Result channel (rsp_): one item per line, sent after its final byte, with
// the three numbers (saturated at 65535) and their found flags. Bytes that
// are not the final one produce nothing.
// Path: a final byte is held in the input register, and its result is then
// registered in the result register. Throughput: one byte per cycle while no
// final byte waits for the result register; each byte is folded into the parse
// state by one compare and multiply-by-ten-plus-digit step.
// Stall: a held result does not block bytes that are not final; a final
// byte waits in the input register until the result register is free, and
// req_ready drops only then.
// Reset: parse state returns to expecting 'h', both registers empty.
`default_nettype none

module http_status_line_parser
   import hslp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_line_byte,
   input  logic                req_end_of_line,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OUT_BITS-1:0] rsp_major_version,
   output logic [OUT_BITS-1:0] rsp_minor_version,
   output logic [OUT_BITS-1:0] rsp_status_code,
   output logic                rsp_major_found,
   output logic                rsp_minor_found,
   output logic                rsp_status_found
);

`include "assert_macros.svh"

   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff;
   logic                s1_eol_ff;
   parse_state_type     st_ff, st_in;
   parse_state_type     st_step;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] major_ff, minor_ff, status_ff;
   logic [2:0]          found_ff;
   logic                out_free;
   logic                s1_fire;
   logic                req_fire;
   logic                emit;

   hslp_step u_step (
      .cur_state (st_ff),
      .line_byte (s1_byte_ff),
      .nxt_state (st_step)
   );

   // Handshake control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_eol_ff || out_free);
   assign emit      = s1_fire && s1_eol_ff;
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire)     s1_valid_in = 1'b1;
      else if (s1_fire) s1_valid_in = 1'b0;

      st_in = st_ff;
      if (emit)         st_in = STATE_CLEAR;
      else if (s1_fire) st_in = st_step;

      rsp_valid_in = rsp_valid_ff;
      if (emit)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         st_ff        <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input and result payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_line_byte;
         s1_eol_ff  <= req_end_of_line;
      end
      if (emit) begin
         major_ff  <= OUT_BITS'(st_step.major);
         minor_ff  <= OUT_BITS'(st_step.minor);
         status_ff <= OUT_BITS'(st_step.status);
         found_ff  <= st_step.found;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_major_version = major_ff;
   assign rsp_minor_version = minor_ff;
   assign rsp_status_code   = status_ff;
   assign rsp_major_found   = found_ff[FND_MAJOR];
   assign rsp_minor_found   = found_ff[FND_MINOR];
   assign rsp_status_found  = found_ff[FND_STATUS];

   // Checks
   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (st_ff.phase == PH_H && !st_ff.stopped && st_ff.found == 3'b000 && !rsp_valid_ff && !s1_valid_ff), "reset did not clear parser")
   `ASSERT_RUN(a_line_restart, clock, reset, emit |=> (st_ff.phase == PH_H && !st_ff.stopped && st_ff.found == 3'b000), "parser not cleared after final byte")
   `ASSERT_RUN(a_rsp_source, clock, reset, (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(emit), "result appeared without a final byte")
   `ASSERT_RUN(a_found_order, clock, reset, st_ff.found[FND_STATUS] |-> (st_ff.found[FND_MINOR] && st_ff.found[FND_MAJOR]), "status found before version")

endmodule

`default_nettype wire

@@ tb/sv/tb_http_status_line_parser.sv @@
`default_nettype none

module tb_http_status_line_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import hslp_pkg::*;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 9;
   localparam int TARGET_BYTES   = 950;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LIMIT_CYCLES   = 200000;

   // one byte of a status line as it sits in the send queue
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } line_byte_type;

   // fields of one parsed status line
   typedef struct packed {
      logic [OUT_BITS-1:0] major;
      logic [OUT_BITS-1:0] minor;
      logic [OUT_BITS-1:0] status;
      logic                major_f;
      logic                minor_f;
      logic                status_f;
   } status_line_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_line_byte = 8'h00;
   logic                req_end_of_line = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [OUT_BITS-1:0] rsp_major_version;
   logic [OUT_BITS-1:0] rsp_minor_version;
   logic [OUT_BITS-1:0] rsp_status_code;
   logic                rsp_major_found;
   logic                rsp_minor_found;
   logic                rsp_status_found;

   http_status_line_parser u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_line_byte     (req_line_byte),
      .req_end_of_line   (req_end_of_line),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_major_version (rsp_major_version),
      .rsp_minor_version (rsp_minor_version),
      .rsp_status_code   (rsp_status_code),
      .rsp_major_found   (rsp_major_found),
      .rsp_minor_found   (rsp_minor_found),
      .rsp_status_found  (rsp_status_found)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   line_byte_type   line_bytes[$];      // bytes waiting to be offered
   status_line_type expected_lines[$];  // parsed lines not yet seen on rsp_
   logic [7:0]      line_q[$];          // line under construction

   int  send_idle_pct = 6;
   int  recv_idle_pct = 78;
   int  holdoff_request = 0;
   int  holdoff_left = 0;
   bit  byte_taken = 1'b0;
   int  failures = 0;
   int  bytes_queued = 0;
   int  lines_queued = 0;
   int  lines_checked = 0;
   int  major_hits = 0;
   int  minor_hits = 0;
   int  status_hits = 0;
   int  saturated_hits = 0;
   int  cycle_count = 0;

   logic [7:0] ws_chars[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   // ---------------------------------------------------------------
   // Status line predictor
   // ---------------------------------------------------------------
   phase_type             pp_phase;
   logic                  pp_stopped;
   logic [VALUE_BITS-1:0] pp_acc;
   logic [VALUE_BITS-1:0] pp_major;
   logic [VALUE_BITS-1:0] pp_minor;
   logic [VALUE_BITS-1:0] pp_status;
   logic [2:0]            pp_found;

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // acc * 10 + digit, pinned at the top of the value range
   function automatic logic [VALUE_BITS-1:0] digit_step(input logic [VALUE_BITS-1:0] acc,
                                                        input logic [7:0] c);
      logic [31:0] d;
      logic [31:0] top;
      d   = 32'(c - CH_ZERO);
      top = 32'(VALUE_MAX);
      if (32'(acc) > (top - d) / 10)
         return VALUE_MAX;
      return VALUE_BITS'(32'(acc) * 10 + d);
   endfunction

   task automatic clear_parse();
      pp_phase   = PH_H;
      pp_stopped = 1'b0;
      pp_acc     = '0;
      pp_major   = '0;
      pp_minor   = '0;
      pp_status  = '0;
      pp_found   = 3'b000;
   endtask

   task automatic parse_line_byte(input logic [7:0] raw, input logic last);
      logic [7:0]      c;
      status_line_type exp;
      c = raw;
      if (c >= CH_UC_A && c <= CH_UC_Z)
         c = c + CASE_OFS;
      if (!pp_stopped) begin
         case (pp_phase)
            PH_H:     if (c == CH_H) pp_phase = PH_T1; else pp_stopped = 1'b1;
            PH_T1:    if (c == CH_T) pp_phase = PH_T2; else pp_stopped = 1'b1;
            PH_T2:    if (c == CH_T) pp_phase = PH_P; else pp_stopped = 1'b1;
            PH_P:     if (c == CH_P) pp_phase = PH_SLASH; else pp_stopped = 1'b1;
            PH_SLASH: if (c == CH_SLASH) pp_phase = PH_MAJ0; else pp_stopped = 1'b1;
            PH_MAJ0: begin
               if (is_digit(c)) begin
                  pp_acc   = digit_step('0, c);
                  pp_phase = PH_MAJ;
               end else begin
                  pp_stopped = 1'b1;
               end
            end
            PH_MAJ: begin
               if (is_digit(c)) begin
                  pp_acc = digit_step(pp_acc, c);
               end else if (c == CH_DOT) begin
                  pp_major            = pp_acc;
                  pp_found[FND_MAJOR] = 1'b1;
                  pp_acc              = '0;
                  pp_phase            = PH_MIN;
               end else begin
                  pp_stopped = 1'b1;
               end
            end
            PH_MIN: begin
               if (is_digit(c)) begin
                  pp_acc = digit_step(pp_acc, c);
               end else if (is_space(c)) begin
                  pp_minor            = pp_acc;
                  pp_found[FND_MINOR] = 1'b1;
                  pp_phase            = PH_GAP;
               end else begin
                  pp_stopped = 1'b1;
               end
            end
            PH_GAP: begin
               if (is_digit(c)) begin
                  pp_acc   = digit_step('0, c);
                  pp_phase = PH_STAT;
               end else if (!is_space(c)) begin
                  pp_stopped = 1'b1;
               end
            end
            PH_STAT: begin
               // a found status code ends parsing for the line
               if (is_digit(c)) begin
                  pp_acc = digit_step(pp_acc, c);
               end else if (is_space(c)) begin
                  pp_status            = pp_acc;
                  pp_found[FND_STATUS] = 1'b1;
                  pp_stopped           = 1'b1;
               end else begin
                  pp_stopped = 1'b1;
               end
            end
            default: pp_stopped = 1'b1;
         endcase
      end
      if (last) begin
         exp.major    = OUT_BITS'(pp_major);
         exp.minor    = OUT_BITS'(pp_minor);
         exp.status   = OUT_BITS'(pp_status);
         exp.major_f  = pp_found[FND_MAJOR];
         exp.minor_f  = pp_found[FND_MINOR];
         exp.status_f = pp_found[FND_STATUS];
         expected_lines.push_back(exp);
         clear_parse();
      end
   endtask

   // ---------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------
   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic check_status_line();
      status_line_type exp;
      if (expected_lines.size() == 0) begin
         failures++;
         $display("%0t: unexpected result, expected none, got %0d.%0d %0d found %b%b%b",
                  $time, rsp_major_version, rsp_minor_version, rsp_status_code,
                  rsp_major_found, rsp_minor_found, rsp_status_found);
      end else begin
         exp = expected_lines.pop_front();
         compare_field("major_version", 32'(exp.major), 32'(rsp_major_version));
         compare_field("minor_version", 32'(exp.minor), 32'(rsp_minor_version));
         compare_field("status_code", 32'(exp.status), 32'(rsp_status_code));
         compare_field("major_found", 32'(exp.major_f), 32'(rsp_major_found));
         compare_field("minor_found", 32'(exp.minor_f), 32'(rsp_minor_found));
         compare_field("status_found", 32'(exp.status_f), 32'(rsp_status_found));
         lines_checked++;
         major_hits  += int'(exp.major_f);
         minor_hits  += int'(exp.minor_f);
         status_hits += int'(exp.status_f);
         if (exp.major == VALUE_MAX || exp.minor == VALUE_MAX || exp.status == VALUE_MAX)
            saturated_hits++;
      end
   endtask

   // sample both channels on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
      end else begin
         if (rsp_valid && rsp_ready)
            check_status_line();
         if (req_valid && req_ready) begin
            byte_taken = 1'b1;
            parse_line_byte(req_line_byte, req_end_of_line);
         end
      end
   end

   // ---------------------------------------------------------------
   // Byte driver: holds an offered item until taken
   // ---------------------------------------------------------------
   always @(negedge clock) begin : byte_driver
      line_byte_type nb;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !byte_taken) begin
         // still waiting for req_ready
      end else if (line_bytes.size() == 0 || $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
      end else begin
         nb = line_bytes.pop_front();
         req_valid       <= 1'b1;
         req_line_byte   <= nb.ch;
         req_end_of_line <= nb.last;
      end
      byte_taken = 1'b0;
   end

   // Result receiver: random stalls plus one long hold-off in the last phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (holdoff_request != 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles, %0d lines still expected",
                  $time, cycle_count, expected_lines.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Line building
   // ---------------------------------------------------------------
   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_q.push_back(s[i]);
   endtask

   task automatic add_digits(input int n);
      repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(9)));
   endtask

   task automatic add_space();
      line_q.push_back(ws_chars[$urandom_range(5)]);
   endtask

   // move the built line into the send queue, last flag on its final byte
   task automatic flush_line();
      line_byte_type lb;
      for (int i = 0; i < line_q.size(); i++) begin
         lb.ch   = line_q[i];
         lb.last = (i == line_q.size() - 1);
         line_bytes.push_back(lb);
      end
      bytes_queued += line_q.size();
      lines_queued++;
      line_q.delete();
   endtask

   // mostly well-formed status lines, some damaged or cut short, some noise
   task automatic queue_random_line();
      int         kind;
      int         cut;
      bit         wide;
      string      prefix;
      logic [7:0] ch;
      kind   = $urandom_range(99);
      wide   = (kind >= 70);
      prefix = "http/";
      if (kind < 85) begin
         for (int i = 0; i < prefix.len(); i++) begin
            ch = prefix[i];
            if (ch != CH_SLASH && $urandom_range(1))
               ch = ch - CASE_OFS;
            line_q.push_back(ch);
         end
         add_digits(wide ? $urandom_range(5, 8) : $urandom_range(1, 3));
         line_q.push_back(CH_DOT);
         add_digits(wide ? $urandom_range(4, 7) : $urandom_range(0, 3));
         repeat ($urandom_range(1, 3)) add_space();
         add_digits(wide ? $urandom_range(5, 7) : $urandom_range(1, 4));
         if ($urandom_range(9) < 8) begin
            add_space();
            repeat ($urandom_range(0, 5)) line_q.push_back(8'($urandom_range(255)));
         end
         if ($urandom_range(3) == 0)
            line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
         if ($urandom_range(6) == 0) begin
            cut = $urandom_range(1, line_q.size());
            while (line_q.size() > cut)
               void'(line_q.pop_back());
         end
      end else begin
         repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(255)));
         if ($urandom_range(1))
            line_q[0] = CH_H;
      end
      flush_line();
   endtask

   // wait until every queued byte is taken and every line has come back
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (line_bytes.size() != 0 || req_valid || expected_lines.size() != 0);
   endtask

   // ---------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // a lone zero byte, an empty minor with mixed case and a CR ending,
      // then a saturated major with a status code that never terminates
      line_q.push_back(8'h00);
      flush_line();
      add_text("hTtP/0. 9\r");
      flush_line();
      add_text("HTTP/70000.1 5");
      flush_line();

      for (int ph = 0; ph < 3; ph++) begin
         // sender pause: nothing more goes out until all lines are back
         wait_drained();
         send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 78 : 0;
         recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 6 : 0;
         if (ph == 2)
            holdoff_request = HOLDOFF_CYCLES;
         while (bytes_queued < (ph + 1) * TARGET_BYTES / 3)
            queue_random_line();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d lines, %0d results checked", bytes_queued,
               lines_queued, lines_checked);
      $display("Found major %0d, minor %0d, status %0d; lines with a saturated value %0d",
               major_hits, minor_hits, status_hits, saturated_hits);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
